// File: rtl/core/cbp_pkg.sv
// Shared constants, types and helper functions for the color bar pattern sample block.
package cbp_pkg;

	// Frame dimension width, limits and reset values.
	localparam int DIM_W = 13;
	localparam logic [DIM_W-1:0] DIM_MIN = 13'd2;
	localparam logic [DIM_W-1:0] MAX_DIMENSION = 13'd4096;
	localparam logic [DIM_W-1:0] WIDTH_RESET = 13'd640;
	localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

	// Configuration register indexes.
	localparam int CFG_INDEX_W = 4;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 4'd1;

	// Plane codes.
	localparam int KIND_W = 2;
	localparam logic [KIND_W-1:0] KIND_LUMA = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CHROMA_U = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CHROMA_V = 2'd2;

	// Request field widths.
	localparam int COORD_W = 12;
	localparam int PHASE_W = 24;
	localparam int SAMPLE_W = 8;

	// Long division pipeline: dividends are consumed MSB first, a few steps per stage.
	localparam int REM_W = 12;
	localparam int DIVD_W = 32;
	localparam int STEPS_PER_STAGE = 4;
	localparam int DIV_STAGES = DIVD_W / STEPS_PER_STAGE;
	localparam int PIPE_STAGES = DIV_STAGES + 2;
	localparam int BAR_W = 3;
	localparam int RAMP_W = 8;
	localparam int POS_W = 26;
	localparam int PROD_W = 17;

	// Luma ramp and clamp constants.
	localparam logic [4:0] RAMP_SPAN = 5'd24;
	localparam logic [8:0] RAMP_OFFSET = 9'd12;
	localparam logic [8:0] LUMA_MIN = 9'd16;
	localparam logic [8:0] LUMA_MAX = 9'd235;
	localparam logic [8:0] LUMA_LOW_SUM = LUMA_MIN + RAMP_OFFSET;
	localparam logic [8:0] LUMA_HIGH_SUM = LUMA_MAX + RAMP_OFFSET;

	// One division lane: remaining dividend bits and the running remainder.
	typedef struct packed {
		logic [DIVD_W-1:0] dividend;
		logic [REM_W-1:0]  rem;
	} div_lane_t;

	// Result of one restoring division step.
	typedef struct packed {
		div_lane_t lane;
		logic      take;
	} div_step_t;

	// Payload that travels down the pipeline.
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		div_lane_t         bar_lane;
		logic [BAR_W-1:0]  bar;
		div_lane_t         ramp_lane;
		logic [RAMP_W-1:0] ramp;
	} pix_stage_t;

	// One restoring division step: shift in the next dividend bit and subtract if it fits.
	function automatic div_step_t div_step(div_lane_t lane, logic [DIM_W-1:0] divisor);
		logic [DIM_W-1:0] partial;
		div_step_t res;
		partial = {lane.rem, lane.dividend[DIVD_W-1]};
		res.take = (partial >= divisor);
		res.lane.dividend = {lane.dividend[DIVD_W-2:0], 1'b0};
		res.lane.rem = res.take ? REM_W'(partial - divisor) : partial[REM_W-1:0];
		return res;
	endfunction

	// Bar table, luma column.
	function automatic logic [SAMPLE_W-1:0] bar_y(logic [BAR_W-1:0] idx);
		logic [SAMPLE_W-1:0] val;
		unique case (idx)
			3'd0: val = 8'd235;
			3'd1: val = 8'd210;
			3'd2: val = 8'd170;
			3'd3: val = 8'd145;
			3'd4: val = 8'd106;
			3'd5: val = 8'd81;
			3'd6: val = 8'd41;
			3'd7: val = 8'd16;
		endcase
		return val;
	endfunction

	// Bar table, U column.
	function automatic logic [SAMPLE_W-1:0] bar_u(logic [BAR_W-1:0] idx);
		logic [SAMPLE_W-1:0] val;
		unique case (idx)
			3'd0: val = 8'd128;
			3'd1: val = 8'd16;
			3'd2: val = 8'd166;
			3'd3: val = 8'd54;
			3'd4: val = 8'd202;
			3'd5: val = 8'd90;
			3'd6: val = 8'd240;
			3'd7: val = 8'd128;
		endcase
		return val;
	endfunction

	// Bar table, V column.
	function automatic logic [SAMPLE_W-1:0] bar_v(logic [BAR_W-1:0] idx);
		logic [SAMPLE_W-1:0] val;
		unique case (idx)
			3'd0: val = 8'd128;
			3'd1: val = 8'd146;
			3'd2: val = 8'd16;
			3'd3: val = 8'd34;
			3'd4: val = 8'd222;
			3'd5: val = 8'd240;
			3'd6: val = 8'd110;
			3'd7: val = 8'd128;
		endcase
		return val;
	endfunction

	// Limit a written dimension to the supported range.
	function automatic logic [DIM_W-1:0] eff_dim(logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] res;
		priority if (v < DIM_MIN) begin
			res = DIM_MIN;
		end else if (v > MAX_DIMENSION) begin
			res = MAX_DIMENSION;
		end else begin
			res = v;
		end
		return res;
	endfunction

endpackage

// File: rtl/core/cbp_ifs.sv
// Channel interfaces: sample request, sample result and register write.

interface cbp_query_if;
	import cbp_pkg::*;
	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [COORD_W-1:0]  row_index;
	logic [COORD_W-1:0]  column_index;
	logic [PHASE_W-1:0]  frame_phase;
	modport source(output valid, kind, row_index, column_index, frame_phase, input ready);
	modport sink(input valid, kind, row_index, column_index, frame_phase, output ready);
endinterface

interface cbp_sample_if;
	import cbp_pkg::*;
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample_value;
	modport source(output valid, sample_value, input ready);
	modport sink(input valid, sample_value, output ready);
endinterface

interface cbp_cfg_if;
	import cbp_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [DIM_W-1:0]       wdata;
	modport source(output valid, index, wdata, input ready);
	modport sink(input valid, index, wdata, output ready);
endinterface

// File: rtl/core/cbp_prep.sv
// First pipeline stage: forms the bar position and ramp dividends from a request.
module cbp_prep
	import cbp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  logic               valid_in,
	input  logic [KIND_W-1:0]  kind,
	input  logic [COORD_W-1:0] row_index,
	input  logic [COORD_W-1:0] column_index,
	input  logic [PHASE_W-1:0] frame_phase,
	output logic               valid_s1,
	output pix_stage_t         stage_s1
);

	logic [DIM_W-1:0]  x_pos;
	logic [POS_W-1:0]  bar_pos;
	logic [PROD_W-1:0] ramp_prod;
	pix_stage_t        stage_next;

	// Chroma columns are at half resolution, so they count double.
	assign x_pos = (kind == KIND_LUMA) ? {1'b0, column_index} : {column_index, 1'b0};

	// The scroll is twice the phase.
	assign bar_pos = POS_W'(x_pos) + POS_W'({frame_phase, 1'b0});

	// Ramp numerator: row times the ramp span.
	assign ramp_prod = PROD_W'(row_index) * PROD_W'(RAMP_SPAN);

	// The bar dividend carries three extra zero bits so the last quotient bits give the bar.
	always_comb begin
		stage_next.kind = kind;
		stage_next.bar_lane.dividend = DIVD_W'({bar_pos, {BAR_W{1'b0}}});
		stage_next.bar_lane.rem = '0;
		stage_next.bar = '0;
		stage_next.ramp_lane.dividend = DIVD_W'(ramp_prod);
		stage_next.ramp_lane.rem = '0;
		stage_next.ramp = '0;
	end

	// Stage valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= valid_in;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (load) begin
			stage_s1 <= stage_next;
		end
	end

endmodule

// File: rtl/core/cbp_div_stage.sv
// One division pipeline stage: a few restoring steps on the bar and ramp lanes.
module cbp_div_stage
	import cbp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  logic             valid_in,
	input  pix_stage_t       stage_in,
	input  logic [DIM_W-1:0] frame_width,
	input  logic [DIM_W-1:0] frame_height,
	output logic             valid_sk,
	output pix_stage_t       stage_sk
);

	pix_stage_t work;
	div_step_t  bar_step;
	div_step_t  ramp_step;

	// The bar lane keeps only its last quotient bits; the ramp quotient saturates at all ones.
	always_comb begin
		work = stage_in;
		bar_step = '0;
		ramp_step = '0;
		for (int i = 0; i < STEPS_PER_STAGE; i++) begin
			bar_step = div_step(work.bar_lane, frame_width);
			work.bar_lane = bar_step.lane;
			work.bar = {work.bar[BAR_W-2:0], bar_step.take};
			ramp_step = div_step(work.ramp_lane, frame_height);
			work.ramp_lane = ramp_step.lane;
			work.ramp = work.ramp[RAMP_W-1] ? '1 : {work.ramp[RAMP_W-2:0], ramp_step.take};
		end
	end

	// Stage valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sk <= 1'b0;
		end else if (load) begin
			valid_sk <= valid_in;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (load) begin
			stage_sk <= work;
		end
	end

endmodule

// File: rtl/core/cbp_shade.sv
// Last pipeline stage: bar table lookup, luma ramp and clamp, output register.
module cbp_shade
	import cbp_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  logic                valid_in,
	input  pix_stage_t          stage_in,
	output logic                valid_s10,
	output logic [SAMPLE_W-1:0] sample_s10
);

	logic [8:0]          luma_sum;
	logic [SAMPLE_W-1:0] luma_val;
	logic [SAMPLE_W-1:0] sample_next;

	// Bar luma plus ramp, with the offset folded into the clamp limits.
	assign luma_sum = 9'(bar_y(stage_in.bar)) + 9'(stage_in.ramp);

	always_comb begin
		priority if (luma_sum < LUMA_LOW_SUM) begin
			luma_val = SAMPLE_W'(LUMA_MIN);
		end else if (luma_sum > LUMA_HIGH_SUM) begin
			luma_val = SAMPLE_W'(LUMA_MAX);
		end else begin
			luma_val = SAMPLE_W'(luma_sum - RAMP_OFFSET);
		end
	end

	// Plane select; the unused code gives zero.
	always_comb begin
		unique case (stage_in.kind)
			KIND_LUMA:     sample_next = luma_val;
			KIND_CHROMA_U: sample_next = bar_u(stage_in.bar);
			KIND_CHROMA_V: sample_next = bar_v(stage_in.bar);
			default:       sample_next = '0;
		endcase
	end

	// Output valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s10 <= 1'b0;
		end else if (load) begin
			valid_s10 <= valid_in;
		end
	end

	// Output sample register.
	always_ff @(posedge clk) begin
		if (load) begin
			sample_s10 <= sample_next;
		end
	end

endmodule

// File: rtl/core/color_bar_pattern_sample.sv
// Color bar pattern sample top level: register file, pipeline control and stage chain.
//
// Each request names a plane, row, column and frame phase and yields one 8-bit sample of a
// scrolling eight-bar YUV 4:2:0 pattern. The block takes one request per clock unless a stalled
// result holds the pipeline, and passes each request through one setup stage, eight division
// stages of four restoring steps each (the 32-step divisions of the bar position by the frame
// width and of the luma ramp by the frame height) and one lookup and output stage. Every stage
// holds its own valid bit and a stage moves up as soon as the one after it is free, so a stalled
// result only holds back requests once the pipeline is full. Register writes are always accepted;
// width and height are clamped to 2..4096 as they are written and must only change while no
// request is in flight.
module color_bar_pattern_sample
	import cbp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	cbp_query_if.sink    query,
	cbp_sample_if.source sample,
	cbp_cfg_if.sink      cfg
);

	logic [DIM_W-1:0]       frame_width_q;
	logic [DIM_W-1:0]       frame_height_q;
	logic [PIPE_STAGES-1:0] valid_p;
	logic [PIPE_STAGES-1:0] load_p;
	pix_stage_t             stage_p [DIV_STAGES+1];

	// Register writes are always accepted.
	assign cfg.ready = 1'b1;

	// Dimension registers hold the clamped value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= WIDTH_RESET;
			frame_height_q <= HEIGHT_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_FRAME_WIDTH:  frame_width_q <= eff_dim(cfg.wdata);
				REG_FRAME_HEIGHT: frame_height_q <= eff_dim(cfg.wdata);
				default: ;
			endcase
		end
	end

	// A stage loads when it is empty or the stage after it is loading too.
	always_comb begin
		load_p[PIPE_STAGES-1] = !valid_p[PIPE_STAGES-1] || sample.ready;
		for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
			load_p[k] = !valid_p[k] || load_p[k+1];
		end
	end

	assign query.ready = load_p[0];
	assign sample.valid = valid_p[PIPE_STAGES-1];

	// Setup stage.
	cbp_prep u_prep (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (load_p[0]),
		.valid_in     (query.valid),
		.kind         (query.kind),
		.row_index    (query.row_index),
		.column_index (query.column_index),
		.frame_phase  (query.frame_phase),
		.valid_s1     (valid_p[0]),
		.stage_s1     (stage_p[0])
	);

	// Division stages.
	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		cbp_div_stage u_div_stage (
			.clk          (clk),
			.arst_n       (arst_n),
			.load         (load_p[g+1]),
			.valid_in     (valid_p[g]),
			.stage_in     (stage_p[g]),
			.frame_width  (frame_width_q),
			.frame_height (frame_height_q),
			.valid_sk     (valid_p[g+1]),
			.stage_sk     (stage_p[g+1])
		);
	end

	// Lookup and output stage.
	cbp_shade u_shade (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load_p[PIPE_STAGES-1]),
		.valid_in   (valid_p[DIV_STAGES]),
		.stage_in   (stage_p[DIV_STAGES]),
		.valid_s10  (valid_p[PIPE_STAGES-1]),
		.sample_s10 (sample.sample_value)
	);

endmodule
